FILE: design/gwr_pkg.sv
package gwr_pkg;

    // result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_EOL    = 2'd1;
    localparam logic [1:0] KIND_OK     = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // configuration register indexes
    localparam logic CFG_MAX_COLUMNS = 1'b0;
    localparam logic CFG_MAX_LINES   = 1'b1;

    // configuration reset values
    localparam logic [5:0] RST_MAX_COLUMNS = 6'd32;
    localparam logic [7:0] RST_MAX_LINES   = 8'd14;

    // control characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] char_in;
        logic       message_end;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic       run_end;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_CHARS,
        ST_CLOSE,
        ST_STATUS
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic mark_text;
        logic word_sp;
        logic line_eol;
        logic eol_final;
        logic line_rej;
        logic put_char;
        logic put_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_break;
        logic in_last;
        logic rejected;
        logic word_empty;
        logic line_empty;
        logic fits;
        logic lines_full;
        logic last_char;
        logic need_close;
        logic pend_last;
        logic out_free;
    } t_status;

endpackage

FILE: design/gwr_ram.sv
module gwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/gwr_ctrl.sv
module gwr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gwr_pkg::t_status i_status,
    output gwr_pkg::t_cmd    o_cmd
);

    gwr_pkg::t_state r_state;
    gwr_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gwr_pkg::ST_IDLE: begin
                if (i_in_valid && (i_status.in_last
                                   || (i_status.in_break && !i_status.rejected))) begin
                    n_state = gwr_pkg::ST_LEAD;
                end
            end
            gwr_pkg::ST_LEAD: begin
                if (i_status.rejected || i_status.word_empty) begin
                    n_state = gwr_pkg::ST_CLOSE;
                end else if (i_status.line_empty) begin
                    n_state = gwr_pkg::ST_CHARS;
                end else if (i_status.fits) begin
                    if (i_status.out_free) begin
                        n_state = gwr_pkg::ST_CHARS;
                    end
                end else if (i_status.lines_full) begin
                    n_state = gwr_pkg::ST_CLOSE;
                end else if (i_status.out_free) begin
                    n_state = gwr_pkg::ST_CHARS;
                end
            end
            gwr_pkg::ST_CHARS: begin
                if (i_status.out_free && i_status.last_char) begin
                    n_state = gwr_pkg::ST_CLOSE;
                end
            end
            gwr_pkg::ST_CLOSE: begin
                if (!i_status.need_close || i_status.lines_full || i_status.out_free) begin
                    n_state = i_status.pend_last ? gwr_pkg::ST_STATUS : gwr_pkg::ST_IDLE;
                end
            end
            gwr_pkg::ST_STATUS: begin
                if (i_status.out_free) begin
                    n_state = gwr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gwr_pkg::ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            gwr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            gwr_pkg::ST_LEAD: begin
                if (!i_status.rejected && !i_status.word_empty) begin
                    if (i_status.line_empty) begin
                        o_cmd.mark_text = 1'b1;
                    end else if (i_status.fits) begin
                        o_cmd.mark_text = i_status.out_free;
                        o_cmd.word_sp   = i_status.out_free;
                    end else if (i_status.lines_full) begin
                        o_cmd.mark_text = 1'b1;
                        o_cmd.line_rej  = 1'b1;
                    end else begin
                        o_cmd.mark_text = i_status.out_free;
                        o_cmd.line_eol  = i_status.out_free;
                    end
                end
            end
            gwr_pkg::ST_CHARS: begin
                o_cmd.put_char = i_status.out_free;
            end
            gwr_pkg::ST_CLOSE: begin
                if (i_status.need_close) begin
                    if (i_status.lines_full) begin
                        o_cmd.line_rej = 1'b1;
                    end else begin
                        o_cmd.line_eol  = i_status.out_free;
                        o_cmd.eol_final = i_status.out_free && !i_status.pend_last;
                    end
                end
            end
            gwr_pkg::ST_STATUS: begin
                o_cmd.put_status = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> (r_state == gwr_pkg::ST_IDLE))
        else $error("input taken outside idle");
    a_status_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put_status |=> (r_state == gwr_pkg::ST_IDLE))
        else $error("status not followed by idle");
    a_chars_need_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gwr_pkg::ST_CHARS) |-> !i_status.word_empty)
        else $error("character replay with empty word");
`endif

endmodule

FILE: design/gwr_dp.sv
module gwr_dp #(
    parameter int MAX_COLUMNS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gwr_pkg::t_in     i_in_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  gwr_pkg::t_cmd    i_cmd,
    output gwr_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output gwr_pkg::t_out    o_out_data
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [5:0] COL_CAP   = 6'(MAX_COLUMNS);

    logic [5:0]      r_max_columns;
    logic [7:0]      r_max_lines;
    logic [5:0]      r_word_length, n_word_length;
    logic [5:0]      r_line_length, n_line_length;
    logic [7:0]      r_line_count, n_line_count;
    logic            r_saw_text, n_saw_text;
    logic            r_rejected, n_rejected;
    logic            r_pend_nl, n_pend_nl;
    logic            r_pend_last, n_pend_last;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_out_valid, n_out_valid;
    gwr_pkg::t_out   r_out, n_out;

    logic [5:0]      cols;
    logic [7:0]      in_char;
    logic            in_sep;
    logic            in_nl;
    logic            in_word;
    logic            wr_en;
    logic [AW-1:0]   waddr;
    logic [7:0]      rdata;
    logic            last_char;
    logic            fits;
    logic            lines_full;
    logic            out_free;
    logic            need_close;
    logic            emit;

    // column limit saturated to the buffer size
    assign cols = (r_max_columns > COL_CAP) ? COL_CAP : r_max_columns;

    // input byte classification
    assign in_char = i_in_data.char_in;
    assign in_sep  = (in_char == gwr_pkg::CH_SPACE) || (in_char == gwr_pkg::CH_TAB)
                  || (in_char == gwr_pkg::CH_FF) || (in_char == gwr_pkg::CH_VT)
                  || (in_char == gwr_pkg::CH_CR);
    assign in_nl   = (in_char == gwr_pkg::CH_NL);
    assign in_word = !in_sep && !in_nl;

    // word buffer, written only below the saturated column limit
    assign wr_en = i_cmd.take && !r_rejected && in_word && (r_word_length < cols);
    assign waddr = AW'(r_word_length);

    gwr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_COLUMNS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (in_char),
        .i_raddr (n_idx),
        .o_rdata (rdata)
    );

    // placement decisions
    assign last_char  = (6'(r_idx) == (r_word_length - 6'd1));
    assign fits       = (7'(r_line_length) + 7'(r_word_length) + 7'd1) <= 7'(cols);
    assign lines_full = (r_line_count >= r_max_lines);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign need_close = !r_rejected && (r_pend_nl || (r_pend_last && (r_line_length != 6'd0)));
    assign emit       = i_cmd.word_sp || i_cmd.line_eol || i_cmd.put_char || i_cmd.put_status;

    // status to the controller
    always_comb begin
        o_status.in_break   = in_sep || in_nl;
        o_status.in_last    = i_in_data.message_end;
        o_status.rejected   = r_rejected;
        o_status.word_empty = (r_word_length == 6'd0);
        o_status.line_empty = (r_line_length == 6'd0);
        o_status.fits       = fits;
        o_status.lines_full = lines_full;
        o_status.last_char  = last_char;
        o_status.need_close = need_close;
        o_status.pend_last  = r_pend_last;
        o_status.out_free   = out_free;
    end

    // replay index, next address presented to the buffer
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.put_char) begin
            n_idx = last_char ? '0 : r_idx + AW'(1);
        end
    end

    // message state update
    always_comb begin
        n_word_length = r_word_length;
        n_line_length = r_line_length;
        n_line_count  = r_line_count;
        n_saw_text    = r_saw_text;
        n_rejected    = r_rejected;
        n_pend_nl     = r_pend_nl;
        n_pend_last   = r_pend_last;
        if (i_cmd.take) begin
            n_pend_nl   = in_nl;
            n_pend_last = i_in_data.message_end;
            if (!r_rejected && in_word) begin
                if (r_word_length >= cols) begin
                    n_rejected = 1'b1;
                end else begin
                    n_word_length = r_word_length + 6'd1;
                end
            end
        end
        if (i_cmd.mark_text) begin
            n_saw_text = 1'b1;
        end
        if (i_cmd.word_sp) begin
            n_line_length = r_line_length + 6'd1;
        end
        if (i_cmd.line_eol) begin
            n_line_count  = r_line_count + 8'd1;
            n_line_length = 6'd0;
        end
        if (i_cmd.line_rej) begin
            n_rejected = 1'b1;
        end
        if (i_cmd.put_char && last_char) begin
            n_line_length = r_line_length + r_word_length;
            n_word_length = 6'd0;
        end
        if (i_cmd.put_status) begin
            n_word_length = 6'd0;
            n_line_length = 6'd0;
            n_line_count  = 8'd0;
            n_saw_text    = 1'b0;
            n_rejected    = 1'b0;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
        end
        if (i_cmd.word_sp) begin
            n_out.kind     = gwr_pkg::KIND_CHAR;
            n_out.char_out = gwr_pkg::CH_SPACE;
            n_out.run_end  = 1'b0;
        end else if (i_cmd.line_eol) begin
            n_out.kind     = gwr_pkg::KIND_EOL;
            n_out.char_out = 8'd0;
            n_out.run_end  = i_cmd.eol_final;
        end else if (i_cmd.put_char) begin
            n_out.kind     = gwr_pkg::KIND_CHAR;
            n_out.char_out = rdata;
            // last of the transaction unless a status or a line end follows
            n_out.run_end  = last_char && !r_pend_last && !(r_pend_nl && !lines_full);
        end else if (i_cmd.put_status) begin
            n_out.kind     = (!r_rejected && r_saw_text && (r_line_count != 8'd0))
                           ? gwr_pkg::KIND_OK : gwr_pkg::KIND_REJECT;
            n_out.char_out = 8'd0;
            n_out.run_end  = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_columns <= gwr_pkg::RST_MAX_COLUMNS;
            r_max_lines   <= gwr_pkg::RST_MAX_LINES;
            r_word_length <= 6'd0;
            r_line_length <= 6'd0;
            r_line_count  <= 8'd0;
            r_saw_text    <= 1'b0;
            r_rejected    <= 1'b0;
            r_pend_nl     <= 1'b0;
            r_pend_last   <= 1'b0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == gwr_pkg::CFG_MAX_COLUMNS)) begin
                r_max_columns <= i_cfg_data[5:0];
            end
            if (i_cfg_we && (i_cfg_idx == gwr_pkg::CFG_MAX_LINES)) begin
                r_max_lines <= i_cfg_data;
            end
            r_word_length <= n_word_length;
            r_line_length <= n_line_length;
            r_line_count  <= n_line_count;
            r_saw_text    <= n_saw_text;
            r_rejected    <= n_rejected;
            r_pend_nl     <= n_pend_nl;
            r_pend_last   <= n_pend_last;
            r_idx         <= n_idx;
            r_out_valid   <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result written into a full output register");
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.take, i_cmd.word_sp, i_cmd.line_eol, i_cmd.put_char,
                  i_cmd.put_status}))
        else $error("more than one datapath action in a cycle");
    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_status |=> ((r_line_count == 8'd0) && !r_rejected
                              && (r_word_length == 6'd0)))
        else $error("message state not cleared after status");
`endif

endmodule

FILE: design/greedy_word_wrap.sv
// Greedy word wrap: message bytes go in one per transaction and come out as
// character, end-of-line and status results, wrapped into at most max_lines
// lines of at most max_columns characters (max_columns saturates at
// MAX_COLUMNS). A word byte is taken and buffered. A space, tab, form
// feed, vertical tab, carriage return or newline, or the final byte of a
// message, then replays the buffered word through the single read port of
// the word buffer: first the decision on the leading space or line break,
// then each character, then the line close, and last the status on the
// final byte; an output stall holds any of these steps. A rejected message
// ends with a reject status; results already delivered for it are to be
// discarded.
module greedy_word_wrap #(
    parameter int MAX_COLUMNS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gwr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output gwr_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);

    gwr_pkg::t_cmd    cmd;
    gwr_pkg::t_status status;

    // sequencer
    gwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // word buffer, counters and output register
    gwr_dp #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
